>>> src/rwdp_pkg.sv
// Shared types and constants for the register-write DMA packer.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package rwdp_pkg;

  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 32;
  localparam int DEST_W  = 24;
  localparam int MASK_W  = 24;
  localparam int FLAG_W  = 16;
  localparam int INDEX_W = 8;
  localparam int SLOTS   = 4;
  localparam int SLOT_W  = 2;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  // Configuration register indexes (byte address = 4 * index).
  localparam logic [1:0] REG_RING_MASK  = 2'd0;
  localparam logic [1:0] REG_DRAW_START = 2'd1;
  localparam logic [1:0] REG_PAD_REG    = 2'd2;

  localparam logic [MASK_W-1:0] RING_MASK_RESET  = 24'h000000;
  localparam logic [FLAG_W-1:0] DRAW_START_RESET = 16'h0100;
  localparam logic [ADDR_W-1:0] PAD_REG_RESET    = 16'h1C00;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SEL_DIRECT,
    SEL_INDEX,
    SEL_DATA
  } word_sel_t;

  // Controller to datapath.
  typedef struct packed {
    logic              accept;
    logic              load;
    word_sel_t         sel;
    logic [SLOT_W-1:0] emit_slot;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic ring_mode;
    logic flush;
    logic out_free;
  } dp_status_t;

  // Address bits 8..2 form index bits 6..0; address bit 13 forms index bit 7.
  function automatic logic [INDEX_W-1:0] fold_index(input logic [ADDR_W-1:0] addr);
    fold_index = {addr[13], addr[8:2]};
  endfunction

endpackage

>>> src/rwdp_if.sv
// Valid/ready channel interfaces for the register-write DMA packer.
// Depends on rwdp_pkg for field widths.
interface rwdp_in_if import rwdp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] reg_address;
  logic [DATA_W-1:0] reg_data;

  modport source(output valid, output reg_address, output reg_data, input ready);
  modport sink(input valid, input reg_address, input reg_data, output ready);
endinterface

interface rwdp_out_if import rwdp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DEST_W-1:0] dest_address;
  logic [DATA_W-1:0] dest_data;
  logic              to_ring;
  logic              last;

  modport source(output valid, output dest_address, output dest_data, output to_ring,
                 output last, input ready);
  modport sink(input valid, input dest_address, input dest_data, input to_ring,
               input last, output ready);
endinterface

>>> src/rwdp_ctrl.sv
// Controller for the register-write DMA packer: sequences input acceptance
// and the five-word flush. Depends on rwdp_pkg.
module rwdp_ctrl import rwdp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && status.out_free && status.ring_mode && status.flush) begin
          state_nxt = ST_EMIT;
          cnt_nxt   = '0;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cnt_nxt = cnt_r + SLOT_W'(1);
          if (cnt_r == LAST_SLOT) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.load      = 1'b0;
    cmd.sel       = SEL_DIRECT;
    cmd.emit_slot = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = status.out_free;
        cmd.accept = in_valid && status.out_free;
        if (!status.ring_mode) begin
          cmd.load = cmd.accept;
          cmd.sel  = SEL_DIRECT;
        end else begin
          cmd.load = cmd.accept && status.flush;
          cmd.sel  = SEL_INDEX;
        end
      end
      ST_EMIT: begin
        cmd.load = status.out_free;
        cmd.sel  = SEL_DATA;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> src/rwdp_datapath.sv
// Datapath for the register-write DMA packer: group state, held data,
// ring offset and the output register. Depends on rwdp_pkg.
module rwdp_datapath import rwdp_pkg::*; #(
  parameter int RING_ADDR_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] reg_address,
  input  logic [DATA_W-1:0] reg_data,
  input  logic [MASK_W-1:0] ring_mask,
  input  logic [FLAG_W-1:0] draw_start_flag,
  input  logic [ADDR_W-1:0] pad_register,
  input  ctl_cmd_t          cmd,
  output dp_status_t        status,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [DEST_W-1:0] out_dest_address,
  output logic [DATA_W-1:0] out_dest_data,
  output logic              out_to_ring,
  output logic              out_last
);

  logic [DATA_W-1:0]         packed_r;
  logic [DATA_W-1:0]         held_r [SLOTS];
  logic [SLOT_W-1:0]         fill_r;
  logic [RING_ADDR_BITS-1:0] offset_r;
  logic                      out_valid_r;
  logic [DEST_W-1:0]         out_addr_r;
  logic [DATA_W-1:0]         out_data_r;
  logic                      out_ring_r;
  logic                      out_last_r;

  logic [DATA_W-1:0]         index_word;
  logic [INDEX_W-1:0]        in_index;
  logic [INDEX_W-1:0]        pad_index;
  logic [RING_ADDR_BITS-1:0] offset_step;
  logic                      flush;

  assign in_index  = fold_index(reg_address);
  assign pad_index = fold_index(pad_register);
  assign flush     = (fill_r == LAST_SLOT) || ((reg_address & draw_start_flag) != '0);

  // The current write fills its slot; a flush pads every later slot.
  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      index_word[j*INDEX_W +: INDEX_W] = packed_r[j*INDEX_W +: INDEX_W];
      if (SLOT_W'(j) == fill_r) begin
        index_word[j*INDEX_W +: INDEX_W] = packed_r[j*INDEX_W +: INDEX_W] | in_index;
      end else if (flush && SLOT_W'(j) > fill_r) begin
        index_word[j*INDEX_W +: INDEX_W] = packed_r[j*INDEX_W +: INDEX_W] | pad_index;
      end
    end
  end

  assign offset_step = (offset_r + RING_ADDR_BITS'(1)) & RING_ADDR_BITS'(ring_mask);

  assign status.ring_mode = (ring_mask != '0);
  assign status.flush     = flush;
  assign status.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packed_r <= '0;
      fill_r   <= '0;
      offset_r <= '0;
    end else begin
      if (cmd.accept && status.ring_mode) begin
        packed_r <= flush ? '0 : index_word;
        fill_r   <= flush ? '0 : fill_r + SLOT_W'(1);
      end
      if (cmd.load && cmd.sel != SEL_DIRECT) begin
        offset_r <= offset_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && status.ring_mode) begin
      for (int j = 0; j < SLOTS; j++) begin
        if (SLOT_W'(j) == fill_r) begin
          held_r[j] <= reg_data;
        end else if (flush && SLOT_W'(j) > fill_r) begin
          held_r[j] <= '0;
        end
      end
    end
  end

  // Output register: a new word loads only when the previous one is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      unique case (cmd.sel)
        SEL_DIRECT: begin
          out_addr_r <= DEST_W'(reg_address);
          out_data_r <= reg_data;
          out_ring_r <= 1'b0;
          out_last_r <= 1'b1;
        end
        SEL_INDEX: begin
          out_addr_r <= DEST_W'(offset_r);
          out_data_r <= index_word;
          out_ring_r <= 1'b1;
          out_last_r <= 1'b0;
        end
        SEL_DATA: begin
          out_addr_r <= DEST_W'(offset_r);
          out_data_r <= held_r[cmd.emit_slot];
          out_ring_r <= 1'b1;
          out_last_r <= (cmd.emit_slot == LAST_SLOT);
        end
        default: begin
          out_addr_r <= DEST_W'(offset_r);
          out_data_r <= '0;
          out_ring_r <= 1'b0;
          out_last_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dest_address = out_addr_r;
  assign out_dest_data    = out_data_r;
  assign out_to_ring      = out_ring_r;
  assign out_last         = out_last_r;

endmodule

>>> src/register_write_dma_packer_core.sv
// Register-write DMA packer, top level.
// The input channel (in_ch) carries register writes: a 16-bit register byte
// address and 32-bit data. The result channel (out_ch) carries words to store:
// a destination address, a data word, a ring/direct flag and a last marker.
// With ring_mask zero each write leaves as one direct register write. Otherwise
// writes are collected four to a group and a group leaves as an index word
// followed by four data words at consecutive, wrapping ring offsets; a write
// with a draw-start address bit closes its group early, padding the rest.
// Latency: a direct write or a group-closing write shows its first word on
// the cycle after acceptance; a write that only joins a group produces nothing.
// Throughput: while the output register is free, one write per cycle in direct
// mode and while a group fills; a flush holds the input while the controller
// walks the four data words through the single output register.
// When the receiver stalls, the output register holds its word and the input
// is refused until that word is taken. Reset (synchronous, rst_n low) empties
// the group, zeroes the ring offset and restores the register defaults.
// Registers on the APB port: 0x0 ring_mask, 0x4 draw_start_flag, 0x8 pad_register.
module register_write_dma_packer_core import rwdp_pkg::*; #(
  parameter int RING_ADDR_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rwdp_in_if.sink               in_ch,
  rwdp_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [MASK_W-1:0] ring_mask_r;
  logic [FLAG_W-1:0] draw_start_r;
  logic [ADDR_W-1:0] pad_reg_r;
  logic [1:0]        reg_index;
  logic              cfg_write;

  ctl_cmd_t   cmd;
  dp_status_t status;

  assign cfg_pready = 1'b1;
  assign reg_index  = cfg_paddr[3:2];
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_mask_r  <= RING_MASK_RESET;
      draw_start_r <= DRAW_START_RESET;
      pad_reg_r    <= PAD_REG_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_RING_MASK:  ring_mask_r  <= cfg_pwdata[MASK_W-1:0];
        REG_DRAW_START: draw_start_r <= cfg_pwdata[FLAG_W-1:0];
        REG_PAD_REG:    pad_reg_r    <= cfg_pwdata[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_RING_MASK:  cfg_prdata = CFG_DATA_W'(ring_mask_r);
      REG_DRAW_START: cfg_prdata = CFG_DATA_W'(draw_start_r);
      REG_PAD_REG:    cfg_prdata = CFG_DATA_W'(pad_reg_r);
      default:        cfg_prdata = '0;
    endcase
  end

  rwdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rwdp_datapath #(
    .RING_ADDR_BITS (RING_ADDR_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .reg_address      (in_ch.reg_address),
    .reg_data         (in_ch.reg_data),
    .ring_mask        (ring_mask_r),
    .draw_start_flag  (draw_start_r),
    .pad_register     (pad_reg_r),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_dest_address (out_ch.dest_address),
    .out_dest_data    (out_ch.dest_data),
    .out_to_ring      (out_ch.to_ring),
    .out_last         (out_ch.last)
  );

endmodule
